FILE: rtl/fra_pkg.sv
// Package for the fraction arithmetic reduce unit.
// Operand and result widths, operation codes and the adder result type.
// No dependencies.
package fra_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int OPW = OPERAND_WIDTH;
  localparam int PW  = 2 * OPW;        // signed product
  localparam int NW  = 2 * OPW + 1;    // result numerator, adder width
  localparam int DW  = 2 * OPW - 1;    // result denominator
  localparam int MW  = 2 * OPW;        // magnitudes, gcd, quotients
  localparam int KW  = $clog2(MW);     // gcd shift count, divide step count

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_DIV = 2'd3;

  localparam logic signed [OPW-1:0] OP_ONE = OPW'(1);

  typedef struct packed {
    logic                 neg;
    logic signed [NW-1:0] sum;
  } alu_res_t;

endpackage

FILE: rtl/fra_if.sv
// Valid/ready channel interfaces for the fraction arithmetic reduce unit.
// Depends on fra_pkg for field widths.
interface fra_in_if;
  import fra_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [1:0]            cmd;
  logic signed [OPW-1:0] a_num;
  logic signed [OPW-1:0] a_den;
  logic signed [OPW-1:0] b_num;
  logic signed [OPW-1:0] b_den;

  modport source (output valid, cmd, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, cmd, a_num, a_den, b_num, b_den, output ready);
endinterface

interface fra_out_if;
  import fra_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [NW-1:0] res_num;
  logic [DW-1:0]        res_den;

  modport source (output valid, res_num, res_den, input ready);
  modport sink   (input valid, res_num, res_den, output ready);
endinterface

FILE: rtl/fra_mult.sv
// Registered signed operand multiplier, one product per cycle.
// Depends on fra_pkg.
module fra_mult (
  input  logic                           clk,
  input  logic signed [fra_pkg::OPW-1:0] x,
  input  logic signed [fra_pkg::OPW-1:0] y,
  output logic signed [fra_pkg::PW-1:0]  p_r
);
  import fra_pkg::*;

  logic signed [PW-1:0] xe;
  logic signed [PW-1:0] ye;

  assign xe = PW'(x);
  assign ye = PW'(y);

  always_ff @(posedge clk) begin
    p_r <= xe * ye;
  end

endmodule

FILE: rtl/fra_addsub.sv
// Shared add/subtract unit: combine, gcd compare, divide trial, sign fix.
// Depends on fra_pkg.
module fra_addsub (
  input  logic signed [fra_pkg::NW-1:0] a,
  input  logic signed [fra_pkg::NW-1:0] b,
  input  logic                          sub,
  output fra_pkg::alu_res_t             res
);
  import fra_pkg::*;

  logic signed [NW-1:0] sum;

  assign sum     = sub ? (a - b) : (a + b);
  assign res.sum = sum;
  assign res.neg = sum[NW-1];

endmodule

FILE: rtl/fraction_arith_reduce_unit.sv
// Fraction arithmetic with gcd reduction: top level and sequencer.
// Depends on fra_pkg, fra_if, fra_mult and fra_addsub.
//
//   channel   dir   handshake      payload
//   in_ch     in    valid/ready    cmd, a_num, a_den, b_num, b_den
//   out_ch    out   valid/ready    res_num, res_den
//
// Each item runs through the multiplies, combine, magnitudes, gcd loop, gcd shift-back,
// two restoring divisions and sign fix: the gcd loop takes one shift, subtract or swap
// per cycle, and all subtracts, the two restoring divisions and the final sign fix share one adder.
// Synchronous active-low reset returns the sequencer to idle and drops out valid.
// in_ch.ready is high only while idle; a result waits in the output register
// and the next request may be taken meanwhile.
module fraction_arith_reduce_unit (
  input  logic      clk,
  input  logic      rst_n,
  fra_in_if.sink    in_ch,
  fra_out_if.source out_ch
);
  import fra_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL1 = 4'd1;
  localparam logic [3:0] S_MUL2 = 4'd2;
  localparam logic [3:0] S_MUL3 = 4'd3;
  localparam logic [3:0] S_COMB = 4'd4;
  localparam logic [3:0] S_MAG  = 4'd5;
  localparam logic [3:0] S_GCD  = 4'd6;
  localparam logic [3:0] S_GSH  = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_FIX  = 4'd9;

  logic [3:0]            state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [1:0]            cmd_r;
  logic signed [OPW-1:0] an_r, ad_r, bn_r, bd_r;
  logic signed [NW-1:0]  rn_r;
  logic signed [PW-1:0]  tmp_r, rd_r;
  logic                  neg_r;
  logic [MW-1:0]         u_r, v_r, g_r, num_r, den_r, rem_r, quo_r;
  logic [KW-1:0]         k_r, cnt_r;
  logic                  second_r;
  logic signed [NW-1:0]  out_num_r;
  logic [DW-1:0]         out_den_r;

  logic signed [OPW-1:0] mx, my;
  logic signed [PW-1:0]  prod;
  logic signed [NW-1:0]  alu_a, alu_b;
  logic                  alu_sub;
  alu_res_t              alu;

  logic signed [PW-1:0]  rd_eff;
  logic signed [NW-1:0]  rn_neg;
  logic signed [PW-1:0]  rd_neg;
  logic [MW-1:0]         trial;
  logic [MW-1:0]         quo_step;

  fra_mult u_mult (
    .clk (clk),
    .x   (mx),
    .y   (my),
    .p_r (prod)
  );

  fra_addsub u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .res (alu)
  );

  assign in_ch.ready    = (state_r == S_IDLE);
  assign out_ch.valid   = out_valid_r;
  assign out_ch.res_num = out_num_r;
  assign out_ch.res_den = out_den_r;

  assign rd_eff   = (rd_r == '0) ? PW'(1) : rd_r;
  assign rn_neg   = -rn_r;
  assign rd_neg   = -rd_eff;
  assign trial    = {rem_r[MW-2:0], quo_r[MW-1]};
  assign quo_step = {quo_r[MW-2:0], ~alu.neg};

  // multiplier operand select
  always_comb begin
    mx = an_r;
    my = bd_r;
    unique case (state_r)
      S_MUL1: begin
        mx = an_r;
        my = (cmd_r == CMD_MUL) ? bn_r : bd_r;
      end
      S_MUL2: begin
        mx = bn_r;
        my = ad_r;
      end
      S_MUL3: begin
        mx = ad_r;
        my = (cmd_r == CMD_DIV) ? bn_r : bd_r;
      end
      default: begin
        mx = an_r;
        my = bd_r;
      end
    endcase
  end

  // shared adder operand select
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b1;
    unique case (state_r)
      S_COMB: begin
        alu_a   = rn_r;
        alu_b   = (cmd_r == CMD_ADD || cmd_r == CMD_SUB) ? NW'(tmp_r) : '0;
        alu_sub = (cmd_r == CMD_SUB);
      end
      S_GCD: begin
        alu_a = {1'b0, u_r};
        alu_b = {1'b0, v_r};
      end
      S_DIV: begin
        alu_a = {1'b0, trial};
        alu_b = {1'b0, g_r};
      end
      S_FIX: begin
        alu_a   = '0;
        alu_b   = {1'b0, num_r};
        alu_sub = neg_r;
      end
      default: begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_ch.valid && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: if (in_ch.valid) state_nxt = S_MUL1;
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_MUL3;
      S_MUL3: state_nxt = S_COMB;
      S_COMB: state_nxt = S_MAG;
      S_MAG:  state_nxt = S_GCD;
      S_GCD:  if (u_r == '0) state_nxt = S_GSH;
      S_GSH:  if (k_r == '0) state_nxt = S_DIV;
      S_DIV:  if (cnt_r == '0 && second_r) state_nxt = S_FIX;
      S_FIX: begin
        if (!out_valid_r) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          cmd_r <= in_ch.cmd;
          an_r  <= in_ch.a_num;
          bn_r  <= in_ch.b_num;
          ad_r  <= (in_ch.a_den == '0) ? OP_ONE : in_ch.a_den;
          bd_r  <= (in_ch.b_den == '0) ? OP_ONE : in_ch.b_den;
        end
      end
      S_MUL2: rn_r  <= NW'(prod);
      S_MUL3: tmp_r <= prod;
      S_COMB: begin
        rd_r <= prod;
        rn_r <= alu.sum;
      end
      S_MAG: begin
        u_r   <= rn_r[NW-1] ? rn_neg[MW-1:0] : rn_r[MW-1:0];
        num_r <= rn_r[NW-1] ? rn_neg[MW-1:0] : rn_r[MW-1:0];
        v_r   <= rd_eff[PW-1] ? rd_neg : rd_eff;
        den_r <= rd_eff[PW-1] ? rd_neg : rd_eff;
        neg_r <= rn_r[NW-1] ^ rd_eff[PW-1];
        k_r   <= '0;
      end
      S_GCD: begin
        // binary gcd: common twos counted in k, odd pair reduced by subtract
        if (u_r == '0) begin
          g_r <= v_r;
        end else if (!u_r[0] && !v_r[0]) begin
          u_r <= u_r >> 1;
          v_r <= v_r >> 1;
          k_r <= k_r + KW'(1);
        end else if (!u_r[0]) begin
          u_r <= u_r >> 1;
        end else if (!v_r[0]) begin
          v_r <= v_r >> 1;
        end else if (alu.neg) begin
          u_r <= v_r;
          v_r <= u_r;
        end else begin
          u_r <= alu.sum[MW-1:0];
        end
      end
      S_GSH: begin
        if (k_r != '0) begin
          g_r <= g_r << 1;
          k_r <= k_r - KW'(1);
        end else begin
          rem_r    <= '0;
          quo_r    <= num_r;
          cnt_r    <= KW'(MW - 1);
          second_r <= 1'b0;
        end
      end
      S_DIV: begin
        if (cnt_r != '0) begin
          rem_r <= alu.neg ? trial : alu.sum[MW-1:0];
          quo_r <= quo_step;
          cnt_r <= cnt_r - KW'(1);
        end else if (!second_r) begin
          num_r    <= quo_step;
          rem_r    <= '0;
          quo_r    <= den_r;
          cnt_r    <= KW'(MW - 1);
          second_r <= 1'b1;
        end else begin
          den_r <= quo_step;
        end
      end
      S_FIX: begin
        if (!out_valid_r) begin
          out_num_r <= alu.sum;
          out_den_r <= den_r[DW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.res_den != '0)
    else $error("result denominator is zero");

  a_gcd_v_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GCD) |-> v_r != '0)
    else $error("gcd operand v dropped to zero");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> rem_r < g_r)
    else $error("divide remainder not below gcd");

  a_fix_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIX && !out_valid_r) |=> out_valid_r && state_r == S_IDLE)
    else $error("finished result not loaded into output register");

endmodule

FILE: test/tb.sv
// Self-checking testbench for fraction_arith_reduce_unit: directed and random fraction requests
// with bursty input, a stalling result side, and a scoreboard that predicts each reduced fraction.
// Depends on fra_pkg, fra_if and the unit's RTL.
module tb;
  import fra_pkg::*;

  typedef struct {
    logic signed [NW-1:0] num;
    logic [DW-1:0]        den;
  } fraction_t;

  class fraction_checker;
    fraction_t pending_fractions[$];
    int        errors;

    function new();
      errors = 0;
    endfunction

    // cross-multiply, reduce by the gcd of the magnitudes, sign to the numerator
    function fraction_t reduced_fraction(logic [1:0] op,
                                         logic signed [OPW-1:0] an_i, logic signed [OPW-1:0] ad_i,
                                         logic signed [OPW-1:0] bn_i, logic signed [OPW-1:0] bd_i);
      longint    an, ad, bn, bd, rn, rd, x, y, t;
      fraction_t f;
      an = an_i;
      ad = ad_i;
      bn = bn_i;
      bd = bd_i;
      rn = 0;
      rd = 1;
      if (ad == 0) ad = 1;
      if (bd == 0) bd = 1;
      case (op)
        CMD_ADD: begin
          rn = an * bd + bn * ad;
          rd = ad * bd;
        end
        CMD_SUB: begin
          rn = an * bd - bn * ad;
          rd = ad * bd;
        end
        CMD_MUL: begin
          rn = an * bn;
          rd = ad * bd;
        end
        CMD_DIV: begin
          rn = an * bd;
          rd = ad * bn;
        end
      endcase
      // dividing by a zero fraction leaves a zero denominator
      if (rd == 0) rd = 1;
      x = (rn < 0) ? -rn : rn;
      y = (rd < 0) ? -rd : rd;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      rn = rn / x;
      rd = rd / x;
      if (rd < 0) begin
        rn = -rn;
        rd = -rd;
      end
      f.num = NW'(rn);
      f.den = DW'(rd);
      return f;
    endfunction

    function void note_request(logic [1:0] op,
                               logic signed [OPW-1:0] an, logic signed [OPW-1:0] ad,
                               logic signed [OPW-1:0] bn, logic signed [OPW-1:0] bd);
      pending_fractions.push_back(reduced_fraction(op, an, ad, bn, bd));
    endfunction

    function void check_result(logic signed [NW-1:0] num, logic [DW-1:0] den);
      fraction_t want;
      if (pending_fractions.size() == 0) begin
        $display("%0t: unexpected result %0d/%0d", $time, num, den);
        errors++;
        return;
      end
      want = pending_fractions.pop_front();
      if (num !== want.num) begin
        $display("%0t: res_num expected %0d got %0d", $time, want.num, num);
        errors++;
      end
      if (den !== want.den) begin
        $display("%0t: res_den expected %0d got %0d", $time, want.den, den);
        errors++;
      end
    endfunction

    function int pending_count();
      return pending_fractions.size();
    endfunction
  endclass

  localparam int RANDOM_ITEMS = 550;
  localparam int HOLD_AFTER   = 40;    // results seen before the long hold-off
  localparam int HOLD_CYCLES  = 1500;
  localparam int DRAIN_CYCLES = 300;

  localparam logic signed [OPW-1:0] MOST_NEG = {1'b1, {(OPW-1){1'b0}}};
  localparam logic signed [OPW-1:0] MOST_POS = ~MOST_NEG;

  logic clk;
  logic rst_n;

  fra_in_if  in_ch();
  fra_out_if out_ch();

  fraction_arith_reduce_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  fraction_checker sb = new();
  logic [1:0]      all_ops[4] = '{CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV};
  int              burst_left = 0;
  int              results_seen = 0;

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // bursts of requests separated by random gaps, short or long
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      case ($urandom_range(0, 3))
        0:       gap = 0;
        1:       gap = $urandom_range(1, 300);
        default: gap = $urandom_range(1, 12);
      endcase
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic offer_request(logic [1:0] op,
                               logic signed [OPW-1:0] an, logic signed [OPW-1:0] ad,
                               logic signed [OPW-1:0] bn, logic signed [OPW-1:0] bd);
    pace_sender();
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= op;
    in_ch.a_num <= an;
    in_ch.a_den <= ad;
    in_ch.b_num <= bn;
    in_ch.b_den <= bd;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(op, an, ad, bn, bd);
  endtask

  function automatic logic signed [OPW-1:0] random_operand();
    logic signed [OPW-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = OPW'($urandom);
      4, 5, 6:    v = OPW'($urandom_range(0, 40)) - OPW'(20);  // small, reduces often
      7:          v = '0;
      8: begin
        case ($urandom_range(0, 3))
          0:       v = MOST_NEG;
          1:       v = MOST_POS;
          2:       v = '1;
          default: v = OPW'(1);
        endcase
      end
      default: begin
        v = OPW'(1) << $urandom_range(0, OPW-1);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  initial begin
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.cmd    <= CMD_ADD;
    in_ch.a_num  <= '0;
    in_ch.a_den  <= '0;
    in_ch.b_num  <= '0;
    in_ch.b_den  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    offer_request(CMD_ADD, 1, 2, 1, 3);
    offer_request(CMD_SUB, 5, 7, 5, 7);
    offer_request(CMD_MUL, OPW'(-3), 4, 8, OPW'(-9));
    offer_request(CMD_DIV, 3, 4, OPW'(-9), 8);
    offer_request(CMD_ADD, 7, 0, 5, 0);          // both denominators zero
    offer_request(CMD_DIV, 3, 5, 0, 7);          // divide by a zero fraction
    offer_request(CMD_DIV, 0, 0, 0, 0);
    offer_request(CMD_MUL, 0, 13, 17, 19);       // zero numerator
    offer_request(CMD_SUB, 6, OPW'(-4), 1, 2);   // negative denominator
    foreach (all_ops[i]) offer_request(all_ops[i], MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG);
    foreach (all_ops[i]) offer_request(all_ops[i], MOST_NEG, MOST_POS, MOST_NEG, MOST_POS);
    foreach (all_ops[i]) offer_request(all_ops[i], MOST_POS, MOST_NEG, MOST_POS, OPW'(-1));
    offer_request(CMD_SUB, MOST_NEG, MOST_NEG, MOST_POS, 1);
    offer_request(CMD_DIV, MOST_NEG, 1, OPW'(-1), 1);
    offer_request(CMD_SUB, MOST_NEG, OPW'(-1), MOST_POS, 1);

    repeat (RANDOM_ITEMS)
      offer_request(all_ops[2'($urandom_range(0, 3))], random_operand(), random_operand(),
                    random_operand(), random_operand());
    in_ch.valid <= 1'b0;

    while (sb.pending_count() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // result side: stalls follow a rotating pattern that is re-drawn each time its age counter runs out
  initial begin
    logic [15:0] stall_pattern;
    int          pattern_age;
    stall_pattern = '1;
    pattern_age   = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result(out_ch.res_num, out_ch.res_den);
        results_seen++;
        // hold off long enough for the unit to fill up and drop in ready
        if (results_seen == HOLD_AFTER) begin
          out_ch.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
      end
      if (pattern_age == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_pattern = '1;
          1:       stall_pattern = 16'($urandom);
          2:       stall_pattern = 16'($urandom) | 16'($urandom);
          default: stall_pattern = 16'($urandom) & 16'($urandom);
        endcase
        pattern_age = 64;
      end
      pattern_age--;
      out_ch.ready  <= stall_pattern[0];
      stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
      @(posedge clk);
    end
  end

endmodule
